>>> src/flsa_pkg.sv
// Package with the shared widths, codes and controller-to-datapath types of the slot allocator.
`default_nettype none

package flsa_pkg;

	// Field widths fixed by the interface.
	localparam int SLOT_W   = 6;
	localparam int OFFSET_W = 14;
	localparam int EB_W     = 9;

	// Element size handling: saturation limit, reset value and alignment.
	localparam int unsigned EB_MAX      = 256;
	localparam int unsigned EB_RESET    = 8;
	localparam int unsigned ALIGN_BYTES = 8;
	localparam int          ALIGN_SHIFT = 3;

	// Transaction mode codes.
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic mem_rd;       // read the next pointer of the current head
		logic free_push;    // push slot_in onto the free list
		logic link_step;    // write one link of a fresh block
		logic pop;          // take the head and advance to its next pointer
		logic fail;         // record an exhausted allocate
		logic load_out;     // load the output register
		logic out_src_head; // output comes straight from the head register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic head_empty;
		logic pool_full;
		logic link_last;
	} status_t;

endpackage

`default_nettype wire

>>> src/flsa_dp.sv
// Datapath of the slot allocator: next-pointer memory, list head, block linking and offset.
`default_nettype none

module flsa_dp
	import flsa_pkg::*;
#(
	parameter int SLOTS_PER_BLOCK = 8,
	parameter int MAX_BLOCKS      = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cmd_t                cmd,
	output status_t                  status,
	input  wire logic [SLOT_W-1:0]   slot_in,
	input  wire logic                cfg_we,
	input  wire logic [EB_W-1:0]     cfg_wdata,
	output logic      [SLOT_W-1:0]   slot_out,
	output logic      [OFFSET_W-1:0] element_offset,
	output logic                     out_of_slots
);

	localparam int TOTAL = SLOTS_PER_BLOCK * MAX_BLOCKS;
	localparam int PW    = $clog2(TOTAL + 1);
	localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int BW    = $clog2(MAX_BLOCKS + 1);
	localparam int CW    = (SLOTS_PER_BLOCK > 1) ? $clog2(SLOTS_PER_BLOCK) : 1;
	localparam int SX    = (PW > SLOT_W) ? PW : SLOT_W;
	localparam int MW    = (PW + EB_W > OFFSET_W) ? PW + EB_W : OFFSET_W;
	localparam logic [PW-1:0] EMPTY = PW'(TOTAL);

	logic [PW-1:0]   next_free [TOTAL];
	logic [PW-1:0]   rdata_q;
	logic [PW-1:0]   head_q;
	logic [PW-1:0]   gnt_q;
	logic            fail_q;
	logic [BW-1:0]   blocks_q;
	logic [CW-1:0]   cnt_q;
	logic [EB_W-1:0] aligned_q;

	logic [SX-1:0]   slot_ext;
	logic            slot_ok;
	logic [PW-1:0]   base;
	logic [PW-1:0]   link_addr;
	logic [PW-1:0]   link_data;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [PW-1:0]   mem_wdata;
	logic [EB_W-1:0] eb_sat;
	logic [EB_W:0]   eb_round;
	logic [EB_W-1:0] aligned_d;
	logic [PW-1:0]   src_slot;
	logic            src_fail;
	logic [SX-1:0]   src_ext;
	logic [MW-1:0]   product;

	// Slot being freed, widened to compare against the pool size.
	assign slot_ext = SX'(slot_in);
	assign slot_ok  = slot_ext < SX'(TOTAL);

	// First slot of the next unused block and the link written for the current slot.
	assign base      = PW'(blocks_q) * PW'(SLOTS_PER_BLOCK);
	assign link_addr = base + PW'(cnt_q);
	assign link_data = status.link_last ? EMPTY : link_addr + PW'(1);

	assign status.head_empty = (head_q == EMPTY);
	assign status.pool_full  = (blocks_q == BW'(MAX_BLOCKS));
	assign status.link_last  = (cnt_q == CW'(SLOTS_PER_BLOCK - 1));

	// Memory write port: a push or one link of a fresh block.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = link_addr[AW-1:0];
		mem_wdata = link_data;
		if (cmd.free_push && slot_ok) begin
			mem_we    = 1'b1;
			mem_waddr = slot_ext[AW-1:0];
			mem_wdata = head_q;
		end else if (cmd.link_step) begin
			mem_we = 1'b1;
		end
	end

	// Next-pointer memory with a registered read at the head.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			next_free[mem_waddr] <= mem_wdata;
		end
		if (cmd.mem_rd) begin
			rdata_q <= next_free[head_q[AW-1:0]];
		end
	end

	// Element size saturated at the limit and rounded up to the alignment.
	always_comb begin
		eb_sat    = (cfg_wdata > EB_W'(EB_MAX)) ? EB_W'(EB_MAX) : cfg_wdata;
		eb_round  = {1'b0, eb_sat} + (EB_W + 1)'(ALIGN_BYTES - 1);
		aligned_d = EB_W'((eb_round >> ALIGN_SHIFT) << ALIGN_SHIFT);
	end

	// List head, block count, link counter and aligned element size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= EMPTY;
			blocks_q  <= '0;
			cnt_q     <= '0;
			aligned_q <= EB_W'(EB_RESET);
		end else begin
			if (cfg_we) begin
				aligned_q <= aligned_d;
			end
			if (cmd.free_push && slot_ok) begin
				head_q <= slot_ext[PW-1:0];
			end else if (cmd.pop) begin
				head_q <= rdata_q;
			end else if (cmd.link_step && status.link_last) begin
				head_q <= base;
			end
			if (cmd.link_step) begin
				if (status.link_last) begin
					cnt_q    <= '0;
					blocks_q <= blocks_q + BW'(1);
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	// Granted slot held until the output register can take it.
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			gnt_q  <= head_q;
			fail_q <= 1'b0;
		end else if (cmd.fail) begin
			gnt_q  <= '0;
			fail_q <= 1'b1;
		end
	end

	// Output register with the byte offset of the granted slot.
	assign src_slot = cmd.out_src_head ? head_q : gnt_q;
	assign src_fail = cmd.out_src_head ? 1'b0 : fail_q;
	assign src_ext  = SX'(src_slot);
	assign product  = MW'(src_slot) * MW'(aligned_q);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			slot_out       <= src_ext[SLOT_W-1:0];
			element_offset <= product[OFFSET_W-1:0];
			out_of_slots   <= src_fail;
		end
	end

endmodule

`default_nettype wire

>>> src/flsa_ctrl.sv
// Controller of the slot allocator: sequences pushes, block links, pops and the output handshake.
`default_nettype none

module flsa_ctrl
	import flsa_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire logic    mode,
	output logic         out_valid,
	input  wire logic    out_ready,
	output cmd_t         cmd,
	input  wire status_t status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LINK,
		S_RD,
		S_POP,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	// The output register can be loaded when empty or emptied in this cycle.
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Commands and next state.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (mode == MODE_FREE) begin
						cmd.free_push = 1'b1;
					end else if (!status.head_empty) begin
						cmd.mem_rd = 1'b1;
						state_d    = S_POP;
					end else if (status.pool_full) begin
						cmd.fail = 1'b1;
						state_d  = S_EMIT;
					end else begin
						state_d = S_LINK;
					end
				end
			end
			S_LINK: begin
				cmd.link_step = 1'b1;
				if (status.link_last) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_POP;
			end
			S_POP: begin
				cmd.pop = 1'b1;
				if (out_free) begin
					cmd.load_out     = 1'b1;
					cmd.out_src_head = 1'b1;
					state_d          = S_IDLE;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/free_list_slot_allocator_top.sv
// Top level of the fixed-size slot allocator with a LIFO free list.
`default_nettype none

// The allocator hands out slots of a pool of MAX_BLOCKS blocks of SLOTS_PER_BLOCK slots from a
// free list kept in a next-pointer memory. A free transaction pushes slot_in onto the list and
// gives no result. An allocate transaction with a non-empty list first reads the head's next
// pointer from the memory and then pops the head. When the list is empty a fresh block is
// linked first, one memory write per slot, then the head's next pointer is read and the head
// popped. An allocate with the list empty and every block in use returns out_of_slots with
// zero slot and offset. element_offset is the slot times the element size, saturated at 256
// and rounded up to eight bytes. A result waits in the output register while the next
// transaction is taken. The memory needs no clearing after reset.
module free_list_slot_allocator_top
	import flsa_pkg::*;
#(
	parameter int SLOTS_PER_BLOCK = 8,
	parameter int MAX_BLOCKS      = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                mode,
	input  wire logic [SLOT_W-1:0]   slot_in,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic      [SLOT_W-1:0]   slot_out,
	output logic      [OFFSET_W-1:0] element_offset,
	output logic                     out_of_slots,
	input  wire logic                cfg_we,
	input  wire logic [EB_W-1:0]     cfg_wdata
);

	cmd_t    cmd;
	status_t status;

	// Sequencing of transactions.
	flsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	// Free list storage and result computation.
	flsa_dp #(
		.SLOTS_PER_BLOCK (SLOTS_PER_BLOCK),
		.MAX_BLOCKS      (MAX_BLOCKS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.slot_in        (slot_in),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.slot_out       (slot_out),
		.element_offset (element_offset),
		.out_of_slots   (out_of_slots)
	);

endmodule

`default_nettype wire
